// ===== hdl/tli_pkg.sv =====
package tli_pkg;

    // Table size default
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    // Field widths
    localparam int ADDR_W   = 10;
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 32;
    localparam int FRAC_W   = 16;
    localparam int CFG_W    = 11;
    localparam int VALUE_W  = 48;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 48;

    // Operation codes carried in s_tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Saturation limits of the result
    localparam logic [VALUE_W-1:0] VALUE_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_MIN = 48'h8000_0000_0000;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // write the incoming sample into the table
        logic capture;  // latch the incoming query
        logic read;     // fetch both neighbor samples
        logic diff;     // form slope and base sample
        logic mult;     // multiply offset by slope
        logic emit;     // sum, clip and load the output register
    } tli_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free; // output register can take a beat this cycle
    } tli_status_t;

endpackage

// ===== hdl/tli_ctrl.sv =====
module tli_ctrl
    import tli_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_op,
    input  tli_status_t status,
    output tli_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_MULT,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;
    logic   accept;

    assign accept   = s_tvalid && s_tready_reg;
    assign s_tready = s_tready_reg;

    // Decode commands from the current step
    always_comb begin
        cmd         = '0;
        cmd.load    = accept && (s_op == OP_LOAD);
        cmd.capture = accept && (s_op == OP_QUERY);
        cmd.read    = (state_reg == ST_READ);
        cmd.diff    = (state_reg == ST_DIFF);
        cmd.mult    = (state_reg == ST_MULT);
        cmd.emit    = (state_reg == ST_EMIT) && status.out_free;
    end

    // Step through one query; loads finish in the accepting cycle
    always_comb begin
        state_next    = state_reg;
        s_tready_next = s_tready_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_op == OP_QUERY)) begin
                    state_next    = ST_READ;
                    s_tready_next = 1'b0;
                end
            end
            ST_READ: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_MULT;
            ST_MULT: state_next = ST_EMIT;
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next    = ST_IDLE;
                    s_tready_next = 1'b1;
                end
            end
            default: begin
                state_next    = ST_IDLE;
                s_tready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
        end
    end

endmodule

// ===== hdl/tli_datapath.sv =====
module tli_datapath
    import tli_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,
    input  tli_cmd_t            cmd,
    output tli_status_t         status,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);

    localparam int AW    = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EW    = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
    localparam int LEN_W = ($clog2(TABLE_DEPTH + 1) > CFG_W) ? $clog2(TABLE_DEPTH + 1) : CFG_W;
    localparam int CW    = (LEN_W > POS_W - FRAC_W - 1) ? LEN_W : POS_W - FRAC_W - 1;
    localparam int DW    = SAMPLE_W + 1;
    localparam int PW    = POS_W + DW;
    localparam int SW    = PW + 1;

    // Sample table
    logic signed [SAMPLE_W-1:0] mem [TABLE_DEPTH];

    // Input field views
    logic [ADDR_W-1:0]   in_addr;
    logic [SAMPLE_W-1:0] in_sample;
    logic [POS_W-1:0]    in_pos;
    logic [EW-1:0]       addr_ext;

    assign in_addr   = s_tdata[ADDR_W-1:0];
    assign in_sample = s_tdata[ADDR_W+SAMPLE_W-1:ADDR_W];
    assign in_pos    = s_tdata[ADDR_W+SAMPLE_W+POS_W-1:ADDR_W+SAMPLE_W];
    assign addr_ext  = EW'(in_addr);

    // Table length minus one, clamped into 1 .. TABLE_DEPTH-1
    logic [LEN_W-1:0] mm1_reg, mm1_next;
    logic [LEN_W-1:0] len_ext;

    assign len_ext = LEN_W'(cfg_wdata);

    always_comb begin
        mm1_next = mm1_reg;
        if (cfg_we) begin
            if (len_ext < LEN_W'(2))
                mm1_next = LEN_W'(1);
            else if (len_ext > LEN_W'(TABLE_DEPTH))
                mm1_next = LEN_W'(TABLE_DEPTH - 1);
            else
                mm1_next = len_ext - LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            mm1_reg <= LEN_W'(1);
        else
            mm1_reg <= mm1_next;
    end

    // Write loads into the table, drop out-of-range addresses
    always_ff @(posedge aclk) begin
        if (cmd.load && (addr_ext < EW'(TABLE_DEPTH)))
            mem[addr_ext[AW-1:0]] <= in_sample;
    end

    // Capture the query
    logic [POS_W-1:0] pos_reg;
    logic             last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pos_reg  <= in_pos;
            last_reg <= s_tlast;
        end
    end

    // Pick segment: below zero, at or past the last sample, or inside
    logic            below, beyond;
    logic [AW-1:0]   rd_a, rd_b;
    logic [POS_W+1:0] hi_off;
    logic [POS_W-1:0] x_next;

    assign below  = pos_reg[POS_W-1];
    assign beyond = !below && (CW'(pos_reg[POS_W-2:FRAC_W]) >= CW'(mm1_reg));
    assign hi_off = {{2{pos_reg[POS_W-1]}}, pos_reg} - ((POS_W+2)'(mm1_reg) << FRAC_W);

    always_comb begin
        if (below) begin
            rd_a   = AW'(0);
            rd_b   = AW'(1);
            x_next = pos_reg;
        end else if (beyond) begin
            rd_a   = AW'(mm1_reg - LEN_W'(1));
            rd_b   = AW'(mm1_reg);
            x_next = hi_off[POS_W-1:0];
        end else begin
            rd_a   = AW'(pos_reg[POS_W-2:FRAC_W]);
            rd_b   = AW'(pos_reg[POS_W-2:FRAC_W]) + AW'(1);
            x_next = POS_W'(pos_reg[FRAC_W-1:0]);
        end
    end

    // Read both neighbors
    logic signed [SAMPLE_W-1:0] rda_reg, rdb_reg;
    logic signed [POS_W-1:0]    x_reg;
    logic                       use_b_reg;

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            rda_reg   <= mem[rd_a];
            rdb_reg   <= mem[rd_b];
            x_reg     <= x_next;
            use_b_reg <= beyond;
        end
    end

    // Slope and base sample
    logic signed [DW-1:0]       d_reg;
    logic signed [SAMPLE_W-1:0] base_reg;

    always_ff @(posedge aclk) begin
        if (cmd.diff) begin
            d_reg    <= $signed({rdb_reg[SAMPLE_W-1], rdb_reg})
                      - $signed({rda_reg[SAMPLE_W-1], rda_reg});
            base_reg <= use_b_reg ? rdb_reg : rda_reg;
        end
    end

    // Offset times slope
    logic signed [PW-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mult)
            prod_reg <= PW'(x_reg) * PW'(d_reg);
    end

    // Sum and clip to the result width
    logic [SW-1:0]      sum;
    logic               sat;
    logic [VALUE_W-1:0] clipped;

    assign sum = {{(SW-SAMPLE_W-FRAC_W){base_reg[SAMPLE_W-1]}}, base_reg, {FRAC_W{1'b0}}}
               + {prod_reg[PW-1], prod_reg};
    assign sat = (sum[SW-1:VALUE_W-1] != '0) && (sum[SW-1:VALUE_W-1] != '1);

    always_comb begin
        if (!sat)
            clipped = sum[VALUE_W-1:0];
        else if (sum[SW-1])
            clipped = VALUE_MIN;
        else
            clipped = VALUE_MAX;
    end

    // Output register
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;
    logic                m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_tvalid_reg <= 1'b0;
        else if (cmd.emit)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= clipped;
            m_tuser_reg <= sat;
            m_tlast_reg <= last_reg;
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;
    assign m_tuser         = m_tuser_reg;
    assign m_tlast         = m_tlast_reg;

endmodule

// ===== hdl/table_linear_interpolator.sv =====
// Table linear interpolator: load beats (s_tuser = 0) write one signed 16-bit sample
// into the table and are taken one per cycle between queries, with no result; query
// beats (s_tuser = 1) give a signed Q15.16 position and return one Q31.16 value,
// interpolated between the two neighboring samples, extrapolated along the first or
// last two samples outside the table, and clipped to 48 bits with m_tuser flagging
// the clip. A query occupies the block through five steps (accept, table read, slope,
// multiply, sum and clip), and a result waiting in the output register does not hold
// the next query until its final step. cfg_wdata sets the table length (clamped to
// 2 .. TABLE_DEPTH); the user must write it only while the block is idle, and the
// block does not enforce this. Table entries are undefined until loaded.
module table_linear_interpolator
    import tli_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,    // table_length
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,      // sample_address, sample_value, position, pad
    input  logic                s_tuser,      // operation
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,      // value
    output logic                m_tuser,      // saturated
    output logic                m_tlast
);

    tli_cmd_t    cmd;
    tli_status_t status;

    tli_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    tli_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
